// File: src/tmtm_pkg.sv
package tmtm_pkg;

    // Field widths of the stream and configuration payloads.
    localparam int SAMPLE_W   = 19;
    localparam int FRAC_W     = 12;
    localparam int TDATA_W    = ((SAMPLE_W + 7) / 8) * 8;
    localparam int IN_TUSER_W = 1;
    localparam int OUT_TUSER_W = 4;
    localparam int CFG_IDX_W  = 2;

    // Threshold products: signed temperature times a fraction with a zero sign bit.
    localparam int PROD_W     = SAMPLE_W + FRAC_W + 1;
    localparam int FRAC_SHIFT = 10;

    // Samples outside this magnitude are stored as zero.
    localparam int TEMP_LIMIT = 150000;

    // Queue between the front and the back; must be a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic        [FRAC_W-1:0]   t_frac;

    typedef struct packed {
        t_sample crit_temp;
        t_frac   warn_frac;
        t_frac   crit_frac;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [1:0] {
        ALARM_NONE = 2'd0,
        ALARM_WARN = 2'd1,
        ALARM_CRIT = 2'd2
    } t_alarm;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CRIT_TEMP = 2'd0,
        CFG_WARN_FRAC = 2'd1,
        CFG_CRIT_FRAC = 2'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_PREP,
        ST_DIVIDE,
        ST_SIGN,
        ST_RESULT
    } t_back_state;

    localparam t_sample CRIT_TEMP_RST = 19'sd100000;
    localparam t_frac   WARN_FRAC_RST = 12'd922;
    localparam t_frac   CRIT_FRAC_RST = 12'd973;

endpackage

// File: src/tmtm_front.sv
// Accepts samples from the input stream and replaces failed or
// out-of-range readings with zero before they enter the queue.
module tmtm_front (
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [tmtm_pkg::TDATA_W-1:0]      i_s_axis_tdata,
    input  logic [tmtm_pkg::IN_TUSER_W-1:0]   i_s_axis_tuser,
    input  tmtm_pkg::t_q_status               i_q_status,
    output logic                              o_push,
    output tmtm_pkg::t_sample                 o_sample
);

    tmtm_pkg::t_sample w_raw;
    logic              w_in_range;

    assign w_raw      = tmtm_pkg::t_sample'(i_s_axis_tdata[tmtm_pkg::SAMPLE_W-1:0]);
    assign w_in_range = (w_raw >= -tmtm_pkg::TEMP_LIMIT) && (w_raw <= tmtm_pkg::TEMP_LIMIT);

    assign o_s_axis_tready = !i_q_status.full;
    assign o_push          = i_s_axis_tvalid && !i_q_status.full;
    assign o_sample        = (i_s_axis_tuser[0] && w_in_range) ? w_raw : '0;

endmodule

// File: src/tmtm_queue.sv
// Short first-in first-out queue of cleaned samples. The read data is
// registered at each pop and holds until the next one.
module tmtm_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  tmtm_pkg::t_sample     i_sample,
    input  logic                  i_pop,
    output tmtm_pkg::t_sample     o_sample,
    output tmtm_pkg::t_q_status   o_status
);

    tmtm_pkg::t_sample                 r_mem [tmtm_pkg::QUEUE_DEPTH];
    tmtm_pkg::t_sample                 r_rd_data;
    logic [tmtm_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [tmtm_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [tmtm_pkg::QCNT_W-1:0]       r_count;
    logic [tmtm_pkg::QCNT_W-1:0]       n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_sample;
        end
        if (i_pop) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    assign o_sample       = r_rd_data;
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == tmtm_pkg::QCNT_W'(tmtm_pkg::QUEUE_DEPTH));

endmodule

// File: src/tmtm_back.sv
// Ring update, running sum and nonzero count, serial divider and
// threshold compare, ending in the output register.
module tmtm_back #(
    parameter int RING_DEPTH = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tmtm_pkg::t_q_status   i_q_status,
    input  tmtm_pkg::t_sample     i_sample,
    output logic                  o_pop,
    input  tmtm_pkg::t_cfg        i_cfg,
    input  logic                  i_m_axis_tready,
    output logic                  o_m_axis_tvalid,
    output tmtm_pkg::t_sample     o_mean,
    output logic                  o_mean_valid,
    output tmtm_pkg::t_alarm      o_level,
    output logic                  o_wrapped
);

    localparam int POS_W  = $clog2(RING_DEPTH);
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int SUM_W  = tmtm_pkg::SAMPLE_W + $clog2(RING_DEPTH);
    localparam int STEP_W = $clog2(SUM_W + 1);
    localparam int PROD_W = tmtm_pkg::PROD_W;

    tmtm_pkg::t_back_state r_state;
    tmtm_pkg::t_back_state n_state;

    tmtm_pkg::t_sample          r_ring [RING_DEPTH];
    logic [RING_DEPTH-1:0]      r_ring_vld;
    logic [POS_W-1:0]           r_pos;
    tmtm_pkg::t_sample          r_old;
    logic                       r_old_vld;
    logic                       r_item_wrap;
    logic signed [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]           r_count;
    logic                       r_neg;
    logic [SUM_W-1:0]           r_quo;
    logic [CNT_W-1:0]           r_rem;
    logic [STEP_W-1:0]          r_step;
    logic signed [PROD_W-1:0]   r_warn_th;
    logic signed [PROD_W-1:0]   r_crit_th;
    tmtm_pkg::t_sample          r_mean;

    logic                       r_out_vld;
    tmtm_pkg::t_sample          r_out_mean;
    logic                       r_out_mean_vld;
    tmtm_pkg::t_alarm           r_out_level;
    logic                       r_out_wrap;

    logic                       w_load;
    tmtm_pkg::t_sample          w_old;
    logic signed [SUM_W-1:0]    w_sum;
    logic [CNT_W-1:0]           w_count;
    logic signed [PROD_W-1:0]   w_warn_prod;
    logic signed [PROD_W-1:0]   w_crit_prod;
    logic [CNT_W:0]             w_rem_sh;
    logic [CNT_W:0]             w_rem_dif;
    logic                       w_ge;
    logic [tmtm_pkg::SAMPLE_W-1:0] w_quo_lo;
    logic signed [PROD_W-1:0]   w_scaled;
    logic                       w_above_warn;
    logic                       w_at_crit;
    tmtm_pkg::t_alarm           w_level;

    // Control outputs of the sequencer.
    always_comb begin
        o_pop  = (r_state == tmtm_pkg::ST_IDLE) && !i_q_status.empty;
        w_load = (r_state == tmtm_pkg::ST_RESULT) && (!r_out_vld || i_m_axis_tready);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tmtm_pkg::ST_IDLE: begin
                if (!i_q_status.empty) begin
                    n_state = tmtm_pkg::ST_UPDATE;
                end
            end
            tmtm_pkg::ST_UPDATE: n_state = tmtm_pkg::ST_PREP;
            tmtm_pkg::ST_PREP:   n_state = tmtm_pkg::ST_DIVIDE;
            tmtm_pkg::ST_DIVIDE: begin
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    n_state = tmtm_pkg::ST_SIGN;
                end
            end
            tmtm_pkg::ST_SIGN:   n_state = tmtm_pkg::ST_RESULT;
            tmtm_pkg::ST_RESULT: begin
                if (w_load) begin
                    n_state = tmtm_pkg::ST_IDLE;
                end
            end
            default:             n_state = tmtm_pkg::ST_IDLE;
        endcase
    end

    // Running sum and nonzero count after replacing the old entry. The queue
    // holds the popped sample steady through the update cycle.
    assign w_old   = r_old_vld ? r_old : '0;
    assign w_sum   = r_sum - SUM_W'(w_old) + SUM_W'(i_sample);
    assign w_count = r_count + CNT_W'(i_sample != '0) - CNT_W'(w_old != '0);

    assign w_warn_prod = $signed(i_cfg.crit_temp) * $signed({1'b0, i_cfg.warn_frac});
    assign w_crit_prod = $signed(i_cfg.crit_temp) * $signed({1'b0, i_cfg.crit_frac});

    // One restoring division step per cycle.
    assign w_rem_sh  = {r_rem, r_quo[SUM_W-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, r_count});
    assign w_rem_dif = w_rem_sh - {1'b0, r_count};
    assign w_quo_lo  = r_quo[tmtm_pkg::SAMPLE_W-1:0];

    // Exact threshold compare as mean*1024 against temperature*fraction.
    assign w_scaled     = PROD_W'(r_mean) <<< tmtm_pkg::FRAC_SHIFT;
    assign w_above_warn = (w_scaled > r_warn_th);
    assign w_at_crit    = (r_crit_th != '0) && (w_scaled >= r_crit_th);

    always_comb begin
        w_level = tmtm_pkg::ALARM_NONE;
        if ((r_count != '0) && w_above_warn) begin
            w_level = w_at_crit ? tmtm_pkg::ALARM_CRIT : tmtm_pkg::ALARM_WARN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tmtm_pkg::ST_IDLE;
            r_ring_vld <= '0;
            r_pos      <= '0;
            r_sum      <= '0;
            r_count    <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == tmtm_pkg::ST_UPDATE) begin
                r_ring_vld[r_pos] <= 1'b1;
                r_sum             <= w_sum;
                r_count           <= w_count;
                if (r_pos == POS_W'(RING_DEPTH - 1)) begin
                    r_pos <= '0;
                end else begin
                    r_pos <= r_pos + 1'b1;
                end
            end
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Ring storage: read of the slot being replaced, then its write.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_old <= r_ring[r_pos];
        end
        if (r_state == tmtm_pkg::ST_UPDATE) begin
            r_ring[r_pos] <= i_sample;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            tmtm_pkg::ST_IDLE: begin
                if (o_pop) begin
                    r_old_vld <= r_ring_vld[r_pos];
                end
            end
            tmtm_pkg::ST_UPDATE: begin
                r_item_wrap <= (r_pos == POS_W'(RING_DEPTH - 1));
                r_warn_th   <= w_warn_prod;
                r_crit_th   <= w_crit_prod;
            end
            tmtm_pkg::ST_PREP: begin
                r_neg  <= r_sum[SUM_W-1];
                r_quo  <= r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
                r_rem  <= '0;
                r_step <= '0;
            end
            tmtm_pkg::ST_DIVIDE: begin
                r_quo  <= {r_quo[SUM_W-2:0], w_ge};
                r_rem  <= w_ge ? w_rem_dif[CNT_W-1:0] : w_rem_sh[CNT_W-1:0];
                r_step <= r_step + 1'b1;
            end
            tmtm_pkg::ST_SIGN: begin
                if (r_count == '0) begin
                    r_mean <= '0;
                end else if (r_neg) begin
                    r_mean <= tmtm_pkg::t_sample'(-w_quo_lo);
                end else begin
                    r_mean <= tmtm_pkg::t_sample'(w_quo_lo);
                end
            end
            tmtm_pkg::ST_RESULT: begin
                if (w_load) begin
                    r_out_mean     <= r_mean;
                    r_out_mean_vld <= (r_count != '0);
                    r_out_level    <= w_level;
                    r_out_wrap     <= r_item_wrap;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_mean          = r_out_mean;
    assign o_mean_valid    = r_out_mean_vld;
    assign o_level         = r_out_level;
    assign o_wrapped       = r_out_wrap;

endmodule

// File: src/temp_mean_threshold_monitor.sv
// Channel      | Direction | Payload
// -------------+-----------+------------------------------------------------
// s_axis       | in        | tdata: sample_milli; tuser: read_ok
// m_axis       | out       | tdata: mean_milli; tuser: mean_valid,
//              |           |        alarm_level, ring_wrapped
// cfg          | in        | index 0 crit_temp_milli, 1 warn_frac, 2 crit_frac
//
// The back end takes one sample at a time through its update, prepare, divide,
// sign and result states, with SUM_W = 19 + clog2(RING_DEPTH) quotient bits.
// The bit-serial divider that forms the mean dominates that sequence.
// Reset is synchronous and active low; the ring reads as all zero after reset
// through per-entry valid bits, so no clearing pass is needed.
// A two-entry queue lets the input keep accepting while the back end works
// or while a finished result waits on a stalled output.
module temp_mean_threshold_monitor #(
    parameter int RING_DEPTH = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [18:0] sample_milli, [23:19] zero padding
    input  logic [tmtm_pkg::TDATA_W-1:0]        i_s_axis_tdata,
    // [0] read_ok
    input  logic [tmtm_pkg::IN_TUSER_W-1:0]     i_s_axis_tuser,

    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [18:0] mean_milli, [23:19] zero padding
    output logic [tmtm_pkg::TDATA_W-1:0]        o_m_axis_tdata,
    // [0] mean_valid, [2:1] alarm_level, [3] ring_wrapped
    output logic [tmtm_pkg::OUT_TUSER_W-1:0]    o_m_axis_tuser,

    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tmtm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tmtm_pkg::SAMPLE_W-1:0]       i_cfg_data
);

    // Configuration registers. The port always takes a write; an index
    // past the register list is dropped.
    tmtm_pkg::t_cfg      r_cfg;

    tmtm_pkg::t_q_status w_q_status;
    logic                w_push;
    logic                w_pop;
    tmtm_pkg::t_sample   w_front_sample;
    tmtm_pkg::t_sample   w_queue_sample;

    tmtm_pkg::t_sample   w_mean;
    logic                w_mean_valid;
    tmtm_pkg::t_alarm    w_level;
    logic                w_wrapped;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.crit_temp <= tmtm_pkg::CRIT_TEMP_RST;
            r_cfg.warn_frac <= tmtm_pkg::WARN_FRAC_RST;
            r_cfg.crit_frac <= tmtm_pkg::CRIT_FRAC_RST;
        end else if (i_cfg_valid) begin
            unique case (tmtm_pkg::t_cfg_index'(i_cfg_index))
                tmtm_pkg::CFG_CRIT_TEMP: begin
                    r_cfg.crit_temp <= tmtm_pkg::t_sample'(i_cfg_data);
                end
                tmtm_pkg::CFG_WARN_FRAC: begin
                    r_cfg.warn_frac <= i_cfg_data[tmtm_pkg::FRAC_W-1:0];
                end
                tmtm_pkg::CFG_CRIT_FRAC: begin
                    r_cfg.crit_frac <= i_cfg_data[tmtm_pkg::FRAC_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The front end cleans each sample and pushes it into the queue.
    tmtm_front u_front (
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_q_status      (w_q_status),
        .o_push          (w_push),
        .o_sample        (w_front_sample)
    );

    tmtm_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_sample (w_front_sample),
        .i_pop    (w_pop),
        .o_sample (w_queue_sample),
        .o_status (w_q_status)
    );

    // The back end updates the ring, divides and classifies.
    tmtm_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_status      (w_q_status),
        .i_sample        (w_queue_sample),
        .o_pop           (w_pop),
        .i_cfg           (r_cfg),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_mean          (w_mean),
        .o_mean_valid    (w_mean_valid),
        .o_level         (w_level),
        .o_wrapped       (w_wrapped)
    );

    assign o_m_axis_tdata = {{(tmtm_pkg::TDATA_W - tmtm_pkg::SAMPLE_W){1'b0}}, w_mean};
    assign o_m_axis_tuser = {w_wrapped, w_level, w_mean_valid};

    // Without a mean there is neither a mean value nor an alarm.
    a_no_mean_is_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !w_mean_valid) |-> (w_mean == '0 && w_level == tmtm_pkg::ALARM_NONE))
        else $error("result without a mean carries a value or an alarm");

    // An alarm is only raised on a valid mean.
    a_alarm_needs_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && w_level != tmtm_pkg::ALARM_NONE) |-> w_mean_valid)
        else $error("alarm raised without a valid mean");

    // The front end never takes a transfer into a full queue.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |-> !w_q_status.full)
        else $error("input transfer accepted while the queue is full");

    // Reset leaves no result pending.
    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result pending right after reset");

endmodule
